// File: sv/hex_lattice_gas_step_engine_defines.svh
// assertion macros used by the checker file of the lattice gas engine
// no dependencies; clocked on clk_i and disabled while rst_ni is low
`ifndef HEX_LATTICE_GAS_STEP_ENGINE_DEFINES_SVH
`define HEX_LATTICE_GAS_STEP_ENGINE_DEFINES_SVH

// overlapping implication, clocked and reset-qualified
`define HLG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked and reset-qualified
`define HLG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hlg_pkg.sv
// types, codes and helper functions of the hexagonal lattice gas engine
// no dependencies; used by the top level, the controller and the datapath
package hlg_pkg;

  // defaults of the grid store size
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;

  // width of a grid dimension, holds sizes up to 8191
  localparam int unsigned DimW = 13;

  // configuration port
  localparam int unsigned ApbAddrW = 4;
  localparam int unsigned ApbDataW = 32;

  localparam logic [15:0] LfsrMask = 16'hB400;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_SOLID = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SEED   = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_COLL,
    OP_STREAM
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COLL,
    ST_STREAM,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [5:0] cell_bits;
    logic       solid_value;
  } req_t;

  typedef struct packed {
    logic [5:0] read_bits;
    logic       read_solid;
    logic       request_done;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    op_e  op;
    logic acc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic coll_last;
    logic strm_last;
  } sts_t;

  function automatic logic [5:0] rot_down(input logic [5:0] v);
    return {v[0], v[5:1]};
  endfunction

  function automatic logic [5:0] rot_up(input logic [5:0] v);
    return {v[4:0], v[5]};
  endfunction

  // fhp collision rule, r picks the turn of a head-on pair
  function automatic logic [5:0] collide(input logic [5:0] v, input logic r);
    logic [5:0] res;
    res = v;
    if (v == 6'h2A) begin
      res = 6'h15;
    end else if (v == 6'h15) begin
      res = 6'h2A;
    end else if (v == 6'h09 || v == 6'h12 || v == 6'h24) begin
      res = r ? rot_down(v) : rot_up(v);
    end
    return res;
  endfunction

  // galois lfsr advance
  function automatic logic [15:0] lfsr_next(input logic [15:0] s);
    return {1'b0, s[15:1]} ^ (s[0] ? LfsrMask : 16'h0000);
  endfunction

endpackage

// File: sv/hex_lattice_gas_step_engine.sv
// top level of the hexagonal lattice gas engine: apb registers and glue
// depends on hlg_pkg, hlg_ctrl and hlg_datapath
//
// usage: a request is taken at a rising edge with start_i high and busy_o
// low; req_i carries the request type, the cell address and the write data.
// each request gets exactly one response: done_o is high for one cycle with
// rsp_o valid, and the receiver takes it at the end of that cycle.
// cell write, solid write and cell read: done_o is high in the cycle right
// after the accept (registered memory read), busy_o drops in the cycle after
// that, so a new such request is taken only after the response.
// step: collision of the (W-2)*(H-2) interior cells at one cell a cycle, then
// a sweep of the W x H area that zeroes each border cell and builds each
// interior cell by one cell read, six post-collision reads through a single
// port and one write, then the response; that single read port sets the pace.
// after reset a clearing pass zeroes the cell and solid memories, one entry
// a cycle over all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) entries (65536 at
// the default size), with busy_o high; register writes are taken during it.
// registers on the apb port: grid width at 0x0, grid height at 0x4, lfsr
// seed at 0x8 (a write reloads the lfsr, a zero seed loads as one).
module hex_lattice_gas_step_engine #(
  parameter int unsigned MAX_WIDTH  = hlg_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hlg_pkg::MaxHeightDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  hlg_pkg::req_t                  req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output hlg_pkg::rsp_t                  rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hlg_pkg::ApbAddrW-1:0]   paddr,
  input  logic [hlg_pkg::ApbDataW-1:0]   pwdata,
  output logic [hlg_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned DW = hlg_pkg::DimW;

  logic [8:0]    width_q, height_q;
  logic [15:0]   seed_q;
  logic          wr_en, seed_ld;
  logic [15:0]   seed_val;
  logic [DW-1:0] dim_w, dim_h, wext, hext;
  hlg_pkg::reg_e reg_sel;
  hlg_pkg::cmd_t cmd;
  hlg_pkg::sts_t sts;
  logic [5:0]    rd_bits;
  logic          rd_solid;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign reg_sel  = hlg_pkg::reg_e'(paddr[3:2]);
  assign seed_ld  = wr_en && (reg_sel == hlg_pkg::REG_SEED);
  assign seed_val = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      seed_q   <= 16'd1;
    end else if (wr_en) begin
      case (reg_sel)
        hlg_pkg::REG_WIDTH:  width_q  <= pwdata[8:0];
        hlg_pkg::REG_HEIGHT: height_q <= pwdata[8:0];
        hlg_pkg::REG_SEED:   seed_q   <= pwdata[15:0];
        default:             seed_q   <= seed_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      hlg_pkg::REG_WIDTH:  prdata = hlg_pkg::ApbDataW'(width_q);
      hlg_pkg::REG_HEIGHT: prdata = hlg_pkg::ApbDataW'(height_q);
      hlg_pkg::REG_SEED:   prdata = hlg_pkg::ApbDataW'(seed_q);
      default:             prdata = '0;
    endcase
  end

  // grid size saturated to the store
  assign wext  = DW'(width_q);
  assign hext  = DW'(height_q);
  assign dim_w = (wext < DW'(3)) ? DW'(3) :
                 (wext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : wext;
  assign dim_h = (hext < DW'(3)) ? DW'(3) :
                 (hext > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : hext;

  hlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .step_req_i (req_i.req_type == hlg_pkg::REQ_STEP),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o),
    .done_o     (done_o)
  );

  hlg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_i        (req_i),
    .dim_w_i      (dim_w),
    .dim_h_i      (dim_h),
    .seed_ld_i    (seed_ld),
    .seed_i       (seed_val),
    .sts_o        (sts),
    .read_bits_o  (rd_bits),
    .read_solid_o (rd_solid)
  );

  // response fields
  assign rsp_o.read_bits    = rd_bits;
  assign rsp_o.read_solid   = rd_solid;
  assign rsp_o.request_done = 1'b1;

endmodule

// File: sv/hlg_ctrl.sv
// controller state machine of the lattice gas engine
// depends on hlg_pkg; drives the datapath through cmd_t, watches sts_t
module hlg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          step_req_i,
  input  hlg_pkg::sts_t sts_i,
  output hlg_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  hlg_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hlg_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = hlg_pkg::OP_IDLE;
    cmd_o.acc  = 1'b0;
    busy_o     = 1'b1;
    done_o     = 1'b0;
    case (state_q)
      hlg_pkg::ST_CLEAR: begin
        cmd_o.op = hlg_pkg::OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = hlg_pkg::ST_IDLE;
        end
      end
      hlg_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.acc = 1'b1;
          state_d   = step_req_i ? hlg_pkg::ST_COLL : hlg_pkg::ST_RESP;
        end
      end
      hlg_pkg::ST_COLL: begin
        cmd_o.op = hlg_pkg::OP_COLL;
        if (sts_i.coll_last) begin
          state_d = hlg_pkg::ST_STREAM;
        end
      end
      hlg_pkg::ST_STREAM: begin
        cmd_o.op = hlg_pkg::OP_STREAM;
        if (sts_i.strm_last) begin
          state_d = hlg_pkg::ST_RESP;
        end
      end
      hlg_pkg::ST_RESP: begin
        done_o  = 1'b1;
        state_d = hlg_pkg::ST_IDLE;
      end
      default: begin
        state_d = hlg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/hlg_datapath.sv
// datapath of the lattice gas engine: cell, solid and post-collision memories,
// sweep counters, lfsr and the streaming merge; depends on hlg_pkg
module hlg_datapath #(
  parameter int unsigned MAX_WIDTH  = hlg_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = hlg_pkg::MaxHeightDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hlg_pkg::cmd_t            cmd_i,
  input  hlg_pkg::req_t            req_i,
  input  logic [hlg_pkg::DimW-1:0] dim_w_i,
  input  logic [hlg_pkg::DimW-1:0] dim_h_i,
  input  logic                     seed_ld_i,
  input  logic [15:0]              seed_i,
  output hlg_pkg::sts_t            sts_o,
  output logic [5:0]               read_bits_o,
  output logic                     read_solid_o
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned DW    = hlg_pkg::DimW;

  logic [5:0] cell_mem  [Depth];
  logic       solid_mem [Depth];
  logic [5:0] post_mem  [Depth];

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [2:0]    j_q, j_d;
  logic [15:0]   lfsr_q;
  logic          p1_vld_q;
  logic [AW-1:0] p1_addr_q;
  logic          rd_q;
  logic          ok_q, ok_d;
  logic [5:0]    acc_q, acc_d;
  logic          sol_q, sol_d;

  logic [5:0]    cell_rdata, post_rdata;
  logic          solid_rdata;

  logic [AW-1:0] cur_addr, in_addr, cell_raddr, post_raddr, cell_waddr;
  logic [5:0]    cell_wdata;
  logic          cell_we, solid_we, solid_wdata;
  logic          in_store, acc_step;
  logic [DW-1:0] xe, ye, wm1, wm2, hm1, hm2, sxe, sye;
  logic          border, cell_done;
  logic [2:0]    src_k, mrg_k;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [5:0]    mrg_mask, merged;

  assign cur_addr = {x_q, y_q};
  assign in_addr  = {XW'(req_i.cell_x), YW'(req_i.cell_y)};
  assign in_store = (DW'(req_i.cell_x) < DW'(MAX_WIDTH)) &&
                    (DW'(req_i.cell_y) < DW'(MAX_HEIGHT));
  assign acc_step = cmd_i.acc && (req_i.req_type == hlg_pkg::REQ_STEP);

  // sweep bounds
  assign xe  = DW'(x_q);
  assign ye  = DW'(y_q);
  assign wm1 = dim_w_i - DW'(1);
  assign wm2 = dim_w_i - DW'(2);
  assign hm1 = dim_h_i - DW'(1);
  assign hm2 = dim_h_i - DW'(2);

  assign border    = (xe == '0) || (ye == '0) || (xe == wm1) || (ye == hm1);
  assign cell_done = border || (j_q == 3'd7);

  assign sts_o.clr_last  = &cur_addr;
  assign sts_o.coll_last = (xe == wm2) && (ye == hm2);
  assign sts_o.strm_last = (xe == wm1) && (ye == hm1);

  // source of direction k for the current target
  assign src_k = j_q - 3'd1;
  always_comb begin
    sx = (src_k < 3'd3) ? x_q - XW'(1) : x_q + XW'(1);
    case (src_k)
      3'd0, 3'd5: sy = y_q + YW'(1);
      3'd2, 3'd3: sy = y_q - YW'(1);
      default:    sy = y_q;
    endcase
  end
  assign sxe        = DW'(sx);
  assign sye        = DW'(sy);
  assign ok_d       = (sxe != '0) && (sxe <= wm2) && (sye != '0) && (sye <= hm2);
  assign post_raddr = {sx, sy};

  // merge of the post-collision bit that arrives this cycle
  assign mrg_k    = j_q - 3'd2;
  assign mrg_mask = 6'b000001 << mrg_k;
  assign merged   = ok_q ? ((acc_q & ~mrg_mask) | (post_rdata & mrg_mask)) : acc_q;

  always_comb begin
    acc_d = acc_q;
    sol_d = sol_q;
    if (j_q == 3'd1) begin
      acc_d = cell_rdata;
      sol_d = solid_rdata;
    end else if (j_q >= 3'd2) begin
      acc_d = merged;
    end
  end

  // memory port selection
  always_comb begin
    cell_raddr  = (cmd_i.op == hlg_pkg::OP_IDLE) ? in_addr : cur_addr;
    cell_we     = 1'b0;
    cell_waddr  = cur_addr;
    cell_wdata  = '0;
    solid_we    = 1'b0;
    solid_wdata = 1'b0;
    case (cmd_i.op)
      hlg_pkg::OP_CLEAR: begin
        cell_we  = 1'b1;
        solid_we = 1'b1;
      end
      hlg_pkg::OP_IDLE: begin
        cell_waddr  = in_addr;
        cell_wdata  = req_i.cell_bits;
        solid_wdata = req_i.solid_value;
        cell_we     = cmd_i.acc && in_store && (req_i.req_type == hlg_pkg::REQ_WRITE);
        solid_we    = cmd_i.acc && in_store && (req_i.req_type == hlg_pkg::REQ_SOLID);
      end
      hlg_pkg::OP_STREAM: begin
        cell_we    = cell_done;
        cell_wdata = border ? 6'd0 : (sol_q ? hlg_pkg::rot_down(merged) : merged);
      end
      default: begin
        cell_we = 1'b0;
      end
    endcase
  end

  // sweep counters
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    j_d = j_q;
    case (cmd_i.op)
      hlg_pkg::OP_CLEAR: begin
        {x_d, y_d} = cur_addr + AW'(1);
      end
      hlg_pkg::OP_IDLE: begin
        if (acc_step) begin
          x_d = XW'(1);
          y_d = YW'(1);
          j_d = '0;
        end
      end
      hlg_pkg::OP_COLL: begin
        if (sts_o.coll_last) begin
          x_d = '0;
          y_d = '0;
          j_d = '0;
        end else if (ye == hm2) begin
          y_d = YW'(1);
          x_d = x_q + XW'(1);
        end else begin
          y_d = y_q + YW'(1);
        end
      end
      hlg_pkg::OP_STREAM: begin
        if (cell_done) begin
          j_d = '0;
          if (ye == hm1) begin
            y_d = '0;
            x_d = x_q + XW'(1);
          end else begin
            y_d = y_q + YW'(1);
          end
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      default: begin
        j_d = j_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      j_q      <= '0;
      lfsr_q   <= 16'd1;
      p1_vld_q <= 1'b0;
      rd_q     <= 1'b0;
    end else begin
      x_q      <= x_d;
      y_q      <= y_d;
      j_q      <= j_d;
      p1_vld_q <= (cmd_i.op == hlg_pkg::OP_COLL);
      rd_q     <= cmd_i.acc && in_store && (req_i.req_type == hlg_pkg::REQ_READ);
      if (seed_ld_i) begin
        lfsr_q <= seed_i;
      end else if (p1_vld_q) begin
        lfsr_q <= hlg_pkg::lfsr_next(lfsr_q);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    p1_addr_q <= cur_addr;
    ok_q      <= ok_d;
    acc_q     <= acc_d;
    sol_q     <= sol_d;
  end

  // cell and solid memories
  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (solid_we) begin
      solid_mem[cell_waddr] <= solid_wdata;
    end
    cell_rdata  <= cell_mem[cell_raddr];
    solid_rdata <= solid_mem[cell_raddr];
  end

  // post-collision memory, written in the cycle after the cell read
  always_ff @(posedge clk_i) begin
    if (p1_vld_q) begin
      post_mem[p1_addr_q] <= hlg_pkg::collide(cell_rdata, lfsr_q[0]);
    end
    post_rdata <= post_mem[post_raddr];
  end

  assign read_bits_o  = rd_q ? cell_rdata : 6'd0;
  assign read_solid_o = rd_q & solid_rdata;

endmodule

// File: sv/hlg_checker.sv
// port-level checks of the lattice gas engine handshake and response timing
// depends on hex_lattice_gas_step_engine_defines.svh; bound to the top level
`include "hex_lattice_gas_step_engine_defines.svh"

module hlg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  // an accepted transaction keeps the block busy until it answers
  `HLG_ASSERT_NXT(a_acc_busy, start_i && !busy_o, busy_o, "no busy after accept")

  // a response only comes while a transaction is open
  `HLG_ASSERT_IMP(a_done_busy, done_o, busy_o, "response while idle")

  // the response closes the transaction
  `HLG_ASSERT_NXT(a_done_free, done_o, !busy_o && !done_o, "block stays busy after response")

endmodule

bind hex_lattice_gas_step_engine hlg_checker u_hlg_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
